// ===== design/lcpf_pkg.sv =====
// Shared constants and the cell control type for the line correlation peak finder.
// Used by lcpf_cell and line_correlation_peak_finder; depends on nothing else.
package lcpf_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int MAX_OFFSET_DEF = 40;
    localparam int MAX_LINE_DEF   = 4096;
    localparam int CFG_WIDTH      = 6;
    localparam int OFF_WIDTH      = 15;
    localparam int SCORE_WIDTH    = 16;
    localparam int APB_ADDR_WIDTH = 2;
    localparam int APB_DATA_WIDTH = 32;

    localparam logic [CFG_WIDTH-1:0]      CFG_MAX_OFFSET_RESET = 6'd8;
    localparam logic [APB_ADDR_WIDTH-1:0] ADDR_MAX_OFFSET      = 2'd0;

    typedef struct packed {
        logic clr;
        logic acc;
        logic shift_neg;
        logic shift_pos;
    } cell_ctrl_t;

endpackage

// ===== design/lcpf_div.sv =====
// Sequential signed divider, one quotient bit per cycle, rounded to nearest.
// Standalone; used by line_correlation_peak_finder.
module lcpf_div #(
    parameter int NUMW = 44,
    parameter int DENW = 34
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [NUMW-1:0] num,
    input  logic signed [DENW-1:0] den,
    output logic                   done,
    output logic signed [NUMW+1:0] quo
);

    localparam int CW = $clog2(NUMW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic            neg_reg;
    logic [CW-1:0]   cnt_reg;
    logic [NUMW:0]   n_reg;
    logic [DENW:0]   rem_reg;
    logic [DENW-1:0] d_reg;

    logic [NUMW-1:0] abs_n;
    logic [DENW-1:0] abs_d;
    logic [DENW:0]   rem_sh;
    logic            qbit;

    always_comb
    begin
        abs_n  = num[NUMW-1] ? (~num + 1'b1) : num;
        abs_d  = den[DENW-1] ? (~den + 1'b1) : den;
        rem_sh = {rem_reg[DENW-1:0], n_reg[NUMW]};
        qbit   = (rem_sh >= {1'b0, d_reg});
        quo    = neg_reg ? -$signed({1'b0, n_reg}) : $signed({1'b0, n_reg});
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NUMW))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUMW-1] ^ den[DENW-1];
            d_reg   <= abs_d;
            n_reg   <= (NUMW+1)'(abs_n) + (NUMW+1)'(abs_d >> 1);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? (rem_sh - {1'b0, d_reg}) : rem_sh;
            n_reg   <= {n_reg[NUMW-1:0], qbit};
        end
    end

endmodule

// ===== design/lcpf_cell.sv =====
// One lag cell: a tap of the sample delay lines and the sums of lags +k and -k.
// Depends on lcpf_pkg.
module lcpf_cell #(
    parameter int SW   = lcpf_pkg::SAMPLE_WIDTH,
    parameter int SUMW = 44
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcpf_pkg::cell_ctrl_t   ctrl,
    input  logic signed [SW-1:0]   r_in,
    input  logic signed [SW-1:0]   c_in,
    input  logic signed [SW-1:0]   prev_ref,
    input  logic signed [SW-1:0]   prev_cmp,
    input  logic signed [SUMW-1:0] neg_in,
    input  logic signed [SUMW-1:0] pos_in,
    output logic signed [SW-1:0]   ref_q,
    output logic signed [SW-1:0]   cmp_q,
    output logic signed [SUMW-1:0] neg_q,
    output logic signed [SUMW-1:0] pos_q
);

    logic signed [SW-1:0]   ref_reg;
    logic signed [SW-1:0]   cmp_reg;
    logic signed [SUMW-1:0] neg_reg;
    logic signed [SUMW-1:0] pos_reg;
    logic signed [2*SW-1:0] p_pos;
    logic signed [2*SW-1:0] p_neg;

    always_comb
    begin
        p_pos = prev_ref * c_in;
        p_neg = r_in * prev_cmp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= '0;
            cmp_reg <= '0;
            neg_reg <= '0;
            pos_reg <= '0;
        end
        else if (ctrl.clr)
        begin
            ref_reg <= '0;
            cmp_reg <= '0;
            neg_reg <= '0;
            pos_reg <= '0;
        end
        else if (ctrl.acc)
        begin
            ref_reg <= prev_ref;
            cmp_reg <= prev_cmp;
            pos_reg <= pos_reg + SUMW'(p_pos);
            neg_reg <= neg_reg + SUMW'(p_neg);
        end
        else
        begin
            if (ctrl.shift_neg)
            begin
                neg_reg <= neg_in;
            end
            if (ctrl.shift_pos)
            begin
                pos_reg <= pos_in;
            end
        end
    end

    assign ref_q = ref_reg;
    assign cmp_q = cmp_reg;
    assign neg_q = neg_reg;
    assign pos_q = pos_reg;

endmodule

// ===== design/line_correlation_peak_finder.sv =====
// Top level: chain of lag cells, peak scan sequencer and shared divider.
// Depends on lcpf_pkg, lcpf_cell and lcpf_div.
//
//   channel   signals                                  direction
//   request   start/busy, ref_sample, cmp_sample, last  in
//   result    done, offset_q8, peak_score, short_line   out
//   config    psel, penable, pwrite, paddr, pwdata,     in/out
//             prdata, pready
//
// A sample pair is taken every cycle that start is high while busy is low.
// The pair marked last starts the peak phase: each searched lag issues a
// division and waits for the divider's done, each skipped lag is stepped
// over, and the sub-sample correction runs one more division when needed.
// A short line holds busy for one cycle. done is held for one cycle only and
// cannot be stalled; reset clears all sums and leaves max_offset at 8.
module line_correlation_peak_finder #(
    parameter int MAX_OFFSET = lcpf_pkg::MAX_OFFSET_DEF,
    parameter int MAX_LINE   = lcpf_pkg::MAX_LINE_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [lcpf_pkg::APB_ADDR_WIDTH-1:0]    paddr,
    input  logic [lcpf_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [lcpf_pkg::APB_DATA_WIDTH-1:0]    prdata,
    output logic                                   pready,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [lcpf_pkg::SAMPLE_WIDTH-1:0] ref_sample,
    input  logic signed [lcpf_pkg::SAMPLE_WIDTH-1:0] cmp_sample,
    input  logic                                   last,
    output logic                                   done,
    output logic signed [lcpf_pkg::OFF_WIDTH-1:0]  offset_q8,
    output logic signed [lcpf_pkg::SCORE_WIDTH-1:0] peak_score,
    output logic                                   short_line
);

    localparam int SW    = lcpf_pkg::SAMPLE_WIDTH;
    localparam int CFGW  = lcpf_pkg::CFG_WIDTH;
    localparam int OFFW  = lcpf_pkg::OFF_WIDTH;
    localparam int SCW   = lcpf_pkg::SCORE_WIDTH;
    localparam int CNTW  = $clog2(MAX_LINE + 1);
    localparam int SUMW  = 2 * SW + $clog2(MAX_LINE);
    localparam int MW    = 2 * SW;
    localparam int NUMW  = (SUMW > MW + 8) ? SUMW : MW + 8;
    localparam int DENW  = (CNTW > MW + 2) ? CNTW : MW + 2;
    localparam int MOW   = $clog2(MAX_OFFSET + 1);
    localparam int LW    = MOW + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_CORR  = 3'd3;
    localparam logic [2:0] ST_CWAIT = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [CFGW-1:0]        max_offset_reg;
    logic [CNTW-1:0]        pair_cnt_reg;
    logic [CNTW-1:0]        len_reg;
    logic [MOW-1:0]         m_reg;
    logic signed [LW-1:0]   lag_reg;
    logic signed [LW-1:0]   best_lag_reg;
    logic signed [MW-1:0]   best_reg;
    logic signed [MW-1:0]   prev_z_reg;
    logic signed [MW-1:0]   zm_reg;
    logic signed [MW-1:0]   zp_reg;
    logic                   want_zp_reg;
    logic                   short_reg;
    logic signed [OFFW-1:0] corr_reg;
    logic                   done_reg;
    logic signed [OFFW-1:0] offset_reg;
    logic signed [SCW-1:0]  score_reg;
    logic                   short_out_reg;

    logic                   accept;
    logic                   room;
    logic [CNTW-1:0]        len_next;
    logic [MOW-1:0]         m_eff;
    logic signed [LW-1:0]   m_s;
    logic [LW-1:0]          lag_abs;
    logic                   lag_out;
    logic                   edge_lag;
    logic                   take;
    logic signed [MW-1:0]   z;
    logic signed [MW+7:0]   corr_num;
    logic signed [MW+1:0]   corr_den;
    logic [CNTW-1:0]        mean_den;
    logic signed [SUMW-1:0] exposed;
    logic                   div_start;
    logic signed [NUMW-1:0] div_num;
    logic signed [DENW-1:0] div_den;
    logic                   div_done;
    logic signed [NUMW+1:0] div_quo;
    logic [MW-1:0]          abs_z0;
    logic [MW-1:0]          rnd_z0;
    logic signed [MW:0]     sc_full;
    logic signed [SCW-1:0]  sc_sat;
    logic signed [OFFW-1:0] off_base;

    lcpf_pkg::cell_ctrl_t   ctrl;

    logic signed [SW-1:0]   ref_q [MAX_OFFSET+1];
    logic signed [SW-1:0]   cmp_q [MAX_OFFSET+1];
    logic signed [SUMW-1:0] neg_q [MAX_OFFSET+1];
    logic signed [SUMW-1:0] pos_q [MAX_OFFSET+1];

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign room     = (pair_cnt_reg < CNTW'(MAX_LINE));
    assign len_next = pair_cnt_reg + CNTW'(room);
    assign pready   = 1'b1;
    assign prdata   = (paddr == lcpf_pkg::ADDR_MAX_OFFSET) ?
                      lcpf_pkg::APB_DATA_WIDTH'(max_offset_reg) : '0;

    always_comb
    begin
        priority if (max_offset_reg == '0)
        begin
            m_eff = MOW'(1);
        end
        else if (32'(max_offset_reg) > MAX_OFFSET)
        begin
            m_eff = MOW'(MAX_OFFSET);
        end
        else
        begin
            m_eff = MOW'(max_offset_reg);
        end
    end

    always_comb
    begin
        m_s      = $signed({1'b0, m_reg});
        lag_abs  = lag_reg[LW-1] ? LW'(-lag_reg) : LW'(lag_reg);
        lag_out  = (lag_abs > {1'b0, m_reg});
        exposed  = lag_reg[LW-1] ? neg_q[MAX_OFFSET] : pos_q[0];
        mean_den = len_reg - CNTW'(lag_abs);
        z        = MW'(div_quo);
        edge_lag = (best_lag_reg == m_s) || (best_lag_reg == -m_s);
        corr_num = ((MW+8)'(zm_reg) - (MW+8)'(zp_reg)) <<< 7;
        corr_den = (MW+2)'(zm_reg) + (MW+2)'(zp_reg) - ((MW+2)'(best_reg) <<< 1);
        priority if (lag_reg[LW-1])
        begin
            take = (lag_reg == -m_s) || (z > best_reg);
        end
        else if (lag_reg == '0)
        begin
            take = !(best_reg > z);
        end
        else
        begin
            take = (z > best_reg);
        end
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = NUMW'(exposed);
        div_den   = DENW'($signed({1'b0, mean_den}));
        if (state_reg == ST_CORR)
        begin
            div_num = NUMW'(corr_num);
            div_den = DENW'(corr_den);
            div_start = !edge_lag && (corr_den != '0);
        end
        else if (state_reg == ST_SCAN)
        begin
            div_start = !lag_out;
        end
    end

    always_comb
    begin
        ctrl.clr       = (state_reg == ST_OUT);
        ctrl.acc       = accept && room;
        ctrl.shift_neg = lag_reg[LW-1] &&
                         (((state_reg == ST_SCAN) && lag_out) ||
                          ((state_reg == ST_DIV) && div_done));
        ctrl.shift_pos = !lag_reg[LW-1] && (state_reg == ST_DIV) && div_done;
    end

    always_comb
    begin
        abs_z0  = best_reg[MW-1] ? MW'(-best_reg) : MW'(best_reg);
        rnd_z0  = (abs_z0 + MW'(128)) >> 8;
        sc_full = best_reg[MW-1] ? -$signed({1'b0, rnd_z0}) : $signed({1'b0, rnd_z0});
        priority if (sc_full > (MW+1)'(32767))
        begin
            sc_sat = 16'sh7FFF;
        end
        else if (sc_full < -(MW+1)'(32768))
        begin
            sc_sat = 16'sh8000;
        end
        else
        begin
            sc_sat = SCW'(sc_full);
        end
        off_base = OFFW'(best_lag_reg) <<< 8;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last)
                begin
                    state_next = (len_next <= CNTW'(m_eff)) ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!lag_out)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = (lag_reg == m_s) ? ST_CORR : ST_SCAN;
                end
            end
            ST_CORR:
            begin
                state_next = div_start ? ST_CWAIT : ST_OUT;
            end
            ST_CWAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            max_offset_reg <= lcpf_pkg::CFG_MAX_OFFSET_RESET;
            pair_cnt_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_OUT);
            if (psel && penable && pwrite)
            begin
                max_offset_reg <= pwdata[CFGW-1:0];
            end
            if (state_reg == ST_OUT)
            begin
                pair_cnt_reg <= '0;
            end
            else if (accept)
            begin
                pair_cnt_reg <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last)
                begin
                    len_reg     <= len_next;
                    m_reg       <= m_eff;
                    short_reg   <= (len_next <= CNTW'(m_eff));
                    lag_reg     <= -LW'(MAX_OFFSET);
                    want_zp_reg <= 1'b0;
                    corr_reg    <= '0;
                end
            end
            ST_SCAN:
            begin
                if (lag_out)
                begin
                    lag_reg <= lag_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (take)
                    begin
                        best_reg     <= z;
                        best_lag_reg <= lag_reg;
                        zm_reg       <= prev_z_reg;
                        want_zp_reg  <= 1'b1;
                    end
                    else if (want_zp_reg)
                    begin
                        zp_reg      <= z;
                        want_zp_reg <= 1'b0;
                    end
                    prev_z_reg <= z;
                    if (lag_reg != m_s)
                    begin
                        lag_reg <= lag_reg + 1'b1;
                    end
                end
            end
            ST_CORR:
            begin
                corr_reg <= '0;
            end
            ST_CWAIT:
            begin
                if (div_done)
                begin
                    corr_reg <= OFFW'(div_quo);
                end
            end
            ST_OUT:
            begin
                short_out_reg <= short_reg;
                offset_reg    <= short_reg ? '0 : off_base + corr_reg;
                score_reg     <= short_reg ? '0 : sc_sat;
            end
            default:
            begin
            end
        endcase
    end

    assign done       = done_reg;
    assign offset_q8  = offset_reg;
    assign peak_score = score_reg;
    assign short_line = short_out_reg;

    lcpf_div #(
        .NUMW (NUMW),
        .DENW (DENW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    for (genvar k = 0; k <= MAX_OFFSET; k++)
    begin : g_cell
        logic signed [SW-1:0]   prev_ref;
        logic signed [SW-1:0]   prev_cmp;
        logic signed [SUMW-1:0] neg_in;
        logic signed [SUMW-1:0] pos_in;

        if (k == 0)
        begin : g_head
            assign prev_ref = ref_sample;
            assign prev_cmp = cmp_sample;
            assign neg_in   = '0;
        end
        else
        begin : g_body
            assign prev_ref = ref_q[k-1];
            assign prev_cmp = cmp_q[k-1];
            assign neg_in   = neg_q[k-1];
        end

        if (k == MAX_OFFSET)
        begin : g_tail
            assign pos_in = '0;
        end
        else
        begin : g_link
            assign pos_in = pos_q[k+1];
        end

        lcpf_cell #(
            .SW   (SW),
            .SUMW (SUMW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .r_in     (ref_sample),
            .c_in     (cmp_sample),
            .prev_ref (prev_ref),
            .prev_cmp (prev_cmp),
            .neg_in   (neg_in),
            .pos_in   (pos_in),
            .ref_q    (ref_q[k]),
            .cmp_q    (cmp_q[k]),
            .neg_q    (neg_q[k]),
            .pos_q    (pos_q[k])
        );
    end

endmodule
